>>> rtl/pbfsp_pkg.sv
// Shared types and constants for the protobuf field stream parser
package pbfsp_pkg;

  // largest accepted message in bytes
  localparam int unsigned MAX_MESSAGE_BYTES = 65536;

  // request queue between parser front and result back end
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_VARINT  = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_END     = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_VARINT  = 3'd1,
    ERR_ZERO    = 3'd2,
    ERR_DECR    = 3'd3,
    ERR_WIRE    = 3'd4,
    ERR_TRUNC   = 3'd5
  } err_e;

  // input request
  typedef struct packed {
    cmd_e        cmd;
    logic [16:0] message_length;
    logic [7:0]  data_byte;
  } in_req_t;

  // output request
  typedef struct packed {
    kind_e       kind;
    logic [31:0] field_number;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic        payload_last;
    err_e        error_code;
    logic        last;
  } out_res_t;

  // queue entry: one result, optionally followed by a message end
  typedef struct packed {
    kind_e       kind;
    logic [31:0] field_number;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic        payload_last;
    err_e        error_code;
    logic        add_end;
  } q_entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/pbfsp_front.sv
// Parser front end: takes requests, decodes varints and queues result entries
module pbfsp_front
  import pbfsp_pkg::*;
#(
  parameter int unsigned MaxMessageBytes = MAX_MESSAGE_BYTES
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_req_t  in_data_i,
  input  q_stat_t  q_stat_i,
  output logic     push_o,
  output q_entry_t entry_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_KEY,
    PH_VALUE,
    PH_LEN,
    PH_PAYLOAD,
    PH_ERROR
  } phase_e;

  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_LEN    = 3'd2;

  phase_e      phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] num_q, num_d;
  logic [31:0] prev_q, prev_d;
  logic [16:0] mleft_q, mleft_d;
  logic [16:0] pleft_q, pleft_d;

  logic        accept;
  logic        active;
  logic [7:0]  b;
  logic [16:0] mleft_n;
  logic [16:0] pleft_n;
  logic [6:0]  shamt;
  logic [63:0] acc_new;
  logic [31:0] key_num;
  logic        vi_bad;
  logic        len_over;
  logic        start_over;
  logic        fail;
  err_e        fail_code;
  logic [31:0] fail_num;
  logic        fdone;

  // input handshake and byte bookkeeping
  assign accept     = in_valid_i && !q_stat_i.full;
  assign b          = in_data_i.data_byte;
  assign active     = (phase_q inside {PH_KEY, PH_VALUE, PH_LEN, PH_PAYLOAD}) &&
                      (mleft_q != '0);
  assign mleft_n    = mleft_q - 17'd1;
  assign pleft_n    = pleft_q - 17'd1;
  assign start_over = {8'd0, in_data_i.message_length} > 25'(MaxMessageBytes);

  // varint byte merge, seven bits per byte
  assign shamt    = 7'({idx_q, 3'b000}) - 7'(idx_q);
  assign acc_new  = acc_q | ({57'd0, b[6:0]} << shamt);
  assign key_num  = acc_new[34:3];
  assign vi_bad   = (idx_q > 4'd9) ||
                    ((idx_q == 4'd9) && (b[7:1] != 7'd0)) ||
                    (!b[7] && (idx_q != 4'd0) && (b == 8'd0));
  assign len_over = (acc_new[63:17] != '0) || (acc_new[16:0] > mleft_n);

  // next state and queue entry
  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    idx_d     = idx_q;
    num_d     = num_q;
    prev_d    = prev_q;
    mleft_d   = mleft_q;
    pleft_d   = pleft_q;
    push_o    = 1'b0;
    entry_o   = '0;
    fail      = 1'b0;
    fail_code = ERR_NONE;
    fail_num  = num_q;
    fdone     = 1'b0;
    if (accept) begin
      if (in_data_i.cmd == CMD_START) begin
        phase_d = PH_IDLE;
        acc_d   = '0;
        idx_d   = '0;
        num_d   = '0;
        prev_d  = '0;
        mleft_d = '0;
        pleft_d = '0;
        if (start_over) begin
          fail      = 1'b1;
          fail_code = ERR_TRUNC;
          fail_num  = '0;
        end else if (in_data_i.message_length == '0) begin
          push_o       = 1'b1;
          entry_o.kind = KIND_END;
        end else begin
          mleft_d = in_data_i.message_length;
          phase_d = PH_KEY;
        end
      end else if (active) begin
        mleft_d = mleft_n;
        if (phase_q == PH_PAYLOAD) begin
          pleft_d              = pleft_n;
          push_o               = 1'b1;
          entry_o.kind         = KIND_PAYLOAD;
          entry_o.field_number = num_q;
          entry_o.payload_byte = b;
          entry_o.payload_last = (pleft_n == '0);
          fdone                = (pleft_n == '0);
        end else if (vi_bad) begin
          fail      = 1'b1;
          fail_code = ERR_VARINT;
        end else if (b[7]) begin
          acc_d = acc_new;
          idx_d = idx_q + 4'd1;
          if (mleft_n == '0) begin
            fail      = 1'b1;
            fail_code = ERR_TRUNC;
          end
        end else begin
          acc_d = '0;
          idx_d = '0;
          case (phase_q)
            PH_KEY: begin
              num_d    = key_num;
              fail_num = key_num;
              if (key_num == '0) begin
                fail      = 1'b1;
                fail_code = ERR_ZERO;
              end else if (key_num < prev_q) begin
                fail      = 1'b1;
                fail_code = ERR_DECR;
              end else begin
                prev_d = key_num;
                if (acc_new[2:0] == WIRE_VARINT) begin
                  phase_d = PH_VALUE;
                end else if (acc_new[2:0] == WIRE_LEN) begin
                  phase_d = PH_LEN;
                end else begin
                  fail      = 1'b1;
                  fail_code = ERR_WIRE;
                end
                if (!fail && (mleft_n == '0)) begin
                  fail      = 1'b1;
                  fail_code = ERR_TRUNC;
                end
              end
            end
            PH_VALUE: begin
              push_o               = 1'b1;
              entry_o.kind         = KIND_VARINT;
              entry_o.field_number = num_q;
              entry_o.field_value  = acc_new;
              fdone                = 1'b1;
            end
            PH_LEN: begin
              if (len_over) begin
                fail      = 1'b1;
                fail_code = ERR_TRUNC;
              end else begin
                push_o               = 1'b1;
                entry_o.kind         = KIND_HEADER;
                entry_o.field_number = num_q;
                entry_o.field_value  = acc_new;
                if (acc_new == '0) begin
                  fdone = 1'b1;
                end else begin
                  pleft_d = acc_new[16:0];
                  phase_d = PH_PAYLOAD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
    // field finished: close the message or wait for the next key
    if (fdone) begin
      if (mleft_n == '0) begin
        entry_o.add_end = 1'b1;
        phase_d         = PH_IDLE;
      end else begin
        phase_d = PH_KEY;
        acc_d   = '0;
        idx_d   = '0;
        num_d   = '0;
      end
    end
    // error aborts the message until the next start
    if (fail) begin
      push_o               = 1'b1;
      entry_o              = '0;
      entry_o.kind         = KIND_ERROR;
      entry_o.field_number = fail_num;
      entry_o.error_code   = fail_code;
      phase_d              = PH_ERROR;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      idx_q   <= '0;
      num_q   <= '0;
      prev_q  <= '0;
      mleft_q <= '0;
      pleft_q <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      idx_q   <= idx_d;
      num_q   <= num_d;
      prev_q  <= prev_d;
      mleft_q <= mleft_d;
      pleft_q <= pleft_d;
    end
  end

  // payload count never outruns the message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> (pleft_q != '0) && (pleft_q <= mleft_q))
    else $error("payload count out of range");

  // varint index stays within ten bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 4'd9)
    else $error("varint index overflow");

  // entries are only pushed while the queue has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_stat_i.full)
    else $error("push into full queue");

endmodule

>>> rtl/pbfsp_queue.sv
// Short entry queue between the parser front and the result back end
module pbfsp_queue
  import pbfsp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output q_entry_t head_o,
  output q_stat_t  stat_o
);

  q_entry_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_q, wr_d;
  logic [QUEUE_PTR_W-1:0] rd_q, rd_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   do_push;
  logic                   do_pop;

  assign stat_o.full  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  // fill count never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule

>>> rtl/pbfsp_back.sv
// Result back end: expands queue entries into output requests
module pbfsp_back
  import pbfsp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_entry_t head_i,
  input  q_stat_t  q_stat_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_res_t out_data_o
);

  out_res_t out_q, out_d;
  logic     valid_q, valid_d;
  logic     pend_q, pend_d;
  logic     load;

  assign load        = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

  // output register refill: pending end first, then the queue head
  always_comb begin
    pop_o   = 1'b0;
    out_d   = out_q;
    valid_d = valid_q && out_stall_i;
    pend_d  = pend_q;
    if (load) begin
      if (pend_q) begin
        out_d      = '0;
        out_d.kind = KIND_END;
        out_d.last = 1'b1;
        valid_d    = 1'b1;
        pend_d     = 1'b0;
      end else if (!q_stat_i.empty) begin
        pop_o              = 1'b1;
        out_d.kind         = head_i.kind;
        out_d.field_number = head_i.field_number;
        out_d.field_value  = head_i.field_value;
        out_d.payload_byte = head_i.payload_byte;
        out_d.payload_last = head_i.payload_last;
        out_d.error_code   = head_i.error_code;
        out_d.last         = !head_i.add_end;
        valid_d            = 1'b1;
        pend_d             = head_i.add_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q   <= '0;
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      out_q   <= out_d;
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  // a pending end always follows a shown result that is not the last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> valid_q && !out_q.last)
    else $error("pending end without open result");

  // a message end always closes its input request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (out_q.kind == KIND_END) |-> out_q.last)
    else $error("message end not marked last");

endmodule

>>> rtl/protobuf_field_stream_parser_unit.sv
// Top level of the protobuf field stream parser
//
//   channel | direction | payload    | handshake
//   --------+-----------+------------+--------------------------
//   in      | input     | in_req_t   | in_valid_i / in_stall_o
//   out     | output    | out_res_t  | out_valid_o / out_stall_i
//
// One input request is taken every cycle while the entry queue has room.
// Each request yields at most one queue entry; the back end turns an entry into
// one or two results, one result per cycle while out_stall_i is low, so an entry
// that closes a message holds the back end for both of its results.
// A result passes the queue storage and then the output register.
// Reset is asynchronous and clears all parser state; no clearing pass.
// in_stall_o is high while the four-entry queue is full.
module protobuf_field_stream_parser_unit
  import pbfsp_pkg::*;
#(
  parameter int unsigned MaxMessageBytes = MAX_MESSAGE_BYTES
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_res_t out_data_o
);

  logic     push;
  logic     pop;
  q_entry_t entry;
  q_entry_t head;
  q_stat_t  q_stat;

  assign in_stall_o = q_stat.full;

  // parser front
  pbfsp_front #(
    .MaxMessageBytes(MaxMessageBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .entry_o    (entry)
  );

  // entry queue
  pbfsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  // result back end
  pbfsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
